@@ hdl/lmr_pkg.sv @@
// Shared constants and types for the learning MAC-to-IP route table.
package lmr_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int MAC_W = 48;
	localparam int IP_W = 32;
	localparam int FUNC_W = 2;
	localparam int HIT_IDX_W = 4;

	localparam logic [IP_W-1:0] SERVER_IP_RST = 32'hC0A8_00A0;

	localparam logic [FUNC_W-1:0] FUNC_DOWN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_UP = 2'd1;

	typedef struct packed {
		logic entry_ok;
		logic wr_en;
		logic capture;
	} cell_ctl_t;

endpackage

@@ hdl/lmr_cell.sv @@
// One table entry: stored key and address, compare, and first-match chain links.
module lmr_cell (
	input  logic                      clk,
	input  lmr_pkg::cell_ctl_t        ctl,
	input  logic [lmr_pkg::MAC_W-1:0] query_mac,
	input  logic [lmr_pkg::IP_W-1:0]  wr_ip,
	input  logic                      any_in,
	output logic                      any_out,
	input  logic                      prior_in,
	output logic                      prior_out,
	output logic                      sel,
	output logic [lmr_pkg::IP_W-1:0]  ip_sel
);

	logic [lmr_pkg::MAC_W-1:0] key_q;
	logic [lmr_pkg::IP_W-1:0]  ip_q;
	logic                      match;
	logic                      match_s2;

	assign match = ctl.entry_ok && (key_q == query_mac);
	assign any_out = any_in | match;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_q <= query_mac;
			ip_q <= wr_ip;
		end
		if (ctl.capture) begin
			match_s2 <= match;
		end
	end

	// earliest match wins
	assign sel = match_s2 & ~prior_in;
	assign prior_out = prior_in | match_s2;
	assign ip_sel = sel ? ip_q : '0;

endmodule

@@ hdl/learning_mac_ip_route_table.sv @@
// Top level of the learning MAC-to-IP route table: staging, cell row, result register.
//
// Channel  Handshake            Payload
// in       in_valid / in_stall  func, dest_mac, src_ip
// out      out_valid / out_stall forward, to_server, forward_ip, hit, hit_index,
//                                learned, table_full
// cfg      cfg_wr_en            cfg_wr_data (server_ip)
//
// One transfer per cycle while out_stall is low; registered through stage 1 and stage 2.
// Stage 1 compares the key in every cell at once and writes a learned entry.
// Stage 2 resolves the first match along the cell row and loads the result register.
// Reset empties the table (entry count zero) and loads the default server address.
// A stalled output holds stage 2, then stage 1, then raises in_stall.
module learning_mac_ip_route_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lmr_pkg::FUNC_W-1:0]   func,
	input  logic [lmr_pkg::MAC_W-1:0]    dest_mac,
	input  logic [lmr_pkg::IP_W-1:0]     src_ip,
	input  logic                         cfg_wr_en,
	input  logic [lmr_pkg::IP_W-1:0]     cfg_wr_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         forward,
	output logic                         to_server,
	output logic [lmr_pkg::IP_W-1:0]     forward_ip,
	output logic                         hit,
	output logic [lmr_pkg::HIT_IDX_W-1:0] hit_index,
	output logic                         learned,
	output logic                         table_full
);

	localparam int DEPTH = lmr_pkg::TABLE_DEPTH;

	logic [lmr_pkg::IP_W-1:0]   server_ip_q;
	logic [lmr_pkg::CNT_W-1:0]  count_q;

	logic                       valid_s1;
	logic [lmr_pkg::FUNC_W-1:0] func_s1;
	logic [lmr_pkg::MAC_W-1:0]  mac_s1;
	logic [lmr_pkg::IP_W-1:0]   sip_s1;

	logic                       valid_s2;
	logic [lmr_pkg::FUNC_W-1:0] func_s2;
	logic                       learned_s2;
	logic                       full_s2;

	logic                       out_valid_q;
	logic                       forward_q;
	logic                       to_server_q;
	logic [lmr_pkg::IP_W-1:0]   forward_ip_q;
	logic                       hit_q;
	logic [lmr_pkg::HIT_IDX_W-1:0] hit_index_q;
	logic                       learned_q;
	logic                       full_q;

	logic                       s1_adv;
	logic                       s2_adv;
	logic                       in_xfer;
	logic                       tbl_full;
	logic                       learn_s1;
	logic                       refuse_s1;

	logic [DEPTH:0]             any_c;
	logic [DEPTH:0]             prior_c;
	logic [DEPTH-1:0]           sel_c;
	logic [lmr_pkg::IP_W-1:0]   ip_c [DEPTH];
	lmr_pkg::cell_ctl_t         ctl_c [DEPTH];

	logic [lmr_pkg::IP_W-1:0]   hit_ip;
	logic [lmr_pkg::IDX_W-1:0]  hit_idx;

	assign s2_adv = valid_s2 & (~out_valid_q | ~out_stall);
	assign s1_adv = valid_s1 & (~valid_s2 | s2_adv);
	assign in_stall = valid_s1 & ~s1_adv;
	assign in_xfer = in_valid & ~in_stall;

	assign tbl_full = (count_q == lmr_pkg::CNT_W'(DEPTH));
	assign learn_s1 = valid_s1 && (func_s1 == lmr_pkg::FUNC_UP) && !any_c[DEPTH] && !tbl_full;
	assign refuse_s1 = (func_s1 == lmr_pkg::FUNC_UP) && !any_c[DEPTH] && tbl_full;

	assign any_c[0] = 1'b0;
	assign prior_c[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl_c[i].entry_ok = (lmr_pkg::CNT_W'(i) < count_q);
		assign ctl_c[i].wr_en = s1_adv & learn_s1 & (count_q == lmr_pkg::CNT_W'(i));
		assign ctl_c[i].capture = s1_adv;

		lmr_cell u_cell (
			.clk       (clk),
			.ctl       (ctl_c[i]),
			.query_mac (mac_s1),
			.wr_ip     (sip_s1),
			.any_in    (any_c[i]),
			.any_out   (any_c[i+1]),
			.prior_in  (prior_c[i]),
			.prior_out (prior_c[i+1]),
			.sel       (sel_c[i]),
			.ip_sel    (ip_c[i])
		);
	end

	always_comb begin
		hit_ip = '0;
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_ip = hit_ip | ip_c[i];
			if (sel_c[i]) begin
				hit_idx = hit_idx | lmr_pkg::IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_ip_q <= lmr_pkg::SERVER_IP_RST;
			count_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				server_ip_q <= cfg_wr_data;
			end
			if (s1_adv && learn_s1) begin
				count_q <= count_q + 1'b1;
			end
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1 <= func;
			mac_s1 <= dest_mac;
			sip_s1 <= src_ip;
		end
		if (s1_adv) begin
			func_s2 <= func_s1;
			learned_s2 <= learn_s1;
			full_s2 <= refuse_s1;
		end
		if (s2_adv) begin
			forward_q <= 1'b0;
			to_server_q <= 1'b0;
			forward_ip_q <= '0;
			hit_q <= 1'b0;
			hit_index_q <= '0;
			learned_q <= 1'b0;
			full_q <= 1'b0;
			case (func_s2)
				lmr_pkg::FUNC_DOWN: begin
					if (prior_c[DEPTH]) begin
						forward_q <= 1'b1;
						forward_ip_q <= hit_ip;
						hit_q <= 1'b1;
						hit_index_q <= lmr_pkg::HIT_IDX_W'(hit_idx);
					end
				end
				lmr_pkg::FUNC_UP: begin
					forward_q <= 1'b1;
					to_server_q <= 1'b1;
					forward_ip_q <= server_ip_q;
					hit_q <= prior_c[DEPTH];
					hit_index_q <= lmr_pkg::HIT_IDX_W'(hit_idx);
					learned_q <= learned_s2;
					full_q <= full_s2;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign forward = forward_q;
	assign to_server = to_server_q;
	assign forward_ip = forward_ip_q;
	assign hit = hit_q;
	assign hit_index = hit_index_q;
	assign learned = learned_q;
	assign table_full = full_q;

endmodule

@@ verif/learning_mac_ip_route_table_tb.sv @@
// Testbench for the learning MAC-to-IP route table: directed rows, random traffic, scoreboard.
module learning_mac_ip_route_table_tb;

	localparam logic [lmr_pkg::FUNC_W-1:0] FUNC_OTHER = 2'd2;
	localparam logic [lmr_pkg::FUNC_W-1:0] FUNC_RSVD = 2'd3;
	localparam int DIRECTED_ROWS = 25;
	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 450;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic                          forward;
		logic                          to_server;
		logic [lmr_pkg::IP_W-1:0]      forward_ip;
		logic                          hit;
		logic [lmr_pkg::HIT_IDX_W-1:0] hit_index;
		logic                          learned;
		logic                          table_full;
	} route_res_t;

	typedef struct {
		logic [lmr_pkg::FUNC_W-1:0] func;
		logic [lmr_pkg::MAC_W-1:0]  mac;
		logic [lmr_pkg::IP_W-1:0]   ip;
		bit                         typed;
		route_res_t                 res;
	} dir_row_t;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

	localparam route_res_t DROPPED = '0;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [lmr_pkg::FUNC_W-1:0]     func;
	logic [lmr_pkg::MAC_W-1:0]      dest_mac;
	logic [lmr_pkg::IP_W-1:0]       src_ip;
	logic                           cfg_wr_en;
	logic [lmr_pkg::IP_W-1:0]       cfg_wr_data;
	logic                           out_valid;
	logic                           out_stall;
	logic                           forward;
	logic                           to_server;
	logic [lmr_pkg::IP_W-1:0]       forward_ip;
	logic                           hit;
	logic [lmr_pkg::HIT_IDX_W-1:0]  hit_index;
	logic                           learned;
	logic                           table_full;

	// predictor state
	logic [lmr_pkg::MAC_W-1:0] known_macs [lmr_pkg::TABLE_DEPTH];
	logic [lmr_pkg::IP_W-1:0]  known_ips [lmr_pkg::TABLE_DEPTH];
	int                        known_count;
	logic [lmr_pkg::IP_W-1:0]  route_server_ip;

	route_res_t expected_routes [$];
	dir_row_t   directed_rows [DIRECTED_ROWS];

	int errors = 0;
	int items_sent;
	int results_checked = 0;
	int hits_seen = 0;
	int learns_seen = 0;
	int refusals_seen = 0;
	int drops_seen = 0;
	int burst_left;
	int idle_cycles = 0;
	int stall_left = 0;
	int stall_tick = 0;
	stall_mode_t stall_mode;

	learning_mac_ip_route_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.dest_mac    (dest_mac),
		.src_ip      (src_ip),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.forward     (forward),
		.to_server   (to_server),
		.forward_ip  (forward_ip),
		.hit         (hit),
		.hit_index   (hit_index),
		.learned     (learned),
		.table_full  (table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic route_res_t predict_route(logic [lmr_pkg::FUNC_W-1:0] f,
			logic [lmr_pkg::MAC_W-1:0] m, logic [lmr_pkg::IP_W-1:0] ip);
		route_res_t r;
		int found;
		r = '0;
		found = -1;
		if (f == lmr_pkg::FUNC_DOWN || f == lmr_pkg::FUNC_UP) begin
			for (int i = 0; i < known_count; i++) begin
				if (found < 0 && known_macs[i] == m)
					found = i;
			end
		end
		if (f == lmr_pkg::FUNC_DOWN && found >= 0) begin
			r.forward = 1'b1;
			r.hit = 1'b1;
			r.hit_index = lmr_pkg::HIT_IDX_W'(found);
			r.forward_ip = known_ips[found];
		end else if (f == lmr_pkg::FUNC_UP) begin
			r.forward = 1'b1;
			r.to_server = 1'b1;
			r.forward_ip = route_server_ip;
			if (found >= 0) begin
				r.hit = 1'b1;
				r.hit_index = lmr_pkg::HIT_IDX_W'(found);
			end else if (known_count < lmr_pkg::TABLE_DEPTH) begin
				known_macs[known_count] = m;
				known_ips[known_count] = ip;
				known_count++;
				r.learned = 1'b1;
			end else begin
				r.table_full = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic dir_row_t mk_row(logic [lmr_pkg::FUNC_W-1:0] f,
			logic [lmr_pkg::MAC_W-1:0] m, logic [lmr_pkg::IP_W-1:0] ip, bit typed,
			route_res_t res);
		dir_row_t row;
		row.func = f;
		row.mac = m;
		row.ip = ip;
		row.typed = typed;
		row.res = res;
		return row;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
		if (errors < MAX_PRINTS)
			$display("mismatch at %0t: %s expected %0h got %0h", $time, what, want_v, got_v);
		errors++;
	endtask

	// one input transfer, with burst/gap pacing on the sender side
	task automatic send_route(logic [lmr_pkg::FUNC_W-1:0] f, logic [lmr_pkg::MAC_W-1:0] m,
			logic [lmr_pkg::IP_W-1:0] ip, bit typed, route_res_t typed_res);
		route_res_t predicted;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		func = f;
		dest_mac = m;
		src_ip = ip;
		do @(posedge clk); while (in_stall);
		predicted = predict_route(f, m, ip);
		expected_routes.push_back(typed ? typed_res : predicted);
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_routes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_server_ip(logic [lmr_pkg::IP_W-1:0] v);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		route_server_ip = v;
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			STALL_NONE: out_stall = 1'b0;
			STALL_RANDOM: out_stall = ($urandom_range(0, 99) < 40);
			default: out_stall = ((stall_tick % 5) < 2);
		endcase
	end

	// result checker
	always @(posedge clk) begin
		route_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_routes.size() == 0) begin
				report_mismatch("result with none pending", 0, 0);
			end else begin
				want = expected_routes.pop_front();
				if (forward !== want.forward)
					report_mismatch("forward", want.forward, forward);
				if (to_server !== want.to_server)
					report_mismatch("to_server", want.to_server, to_server);
				if (forward_ip !== want.forward_ip)
					report_mismatch("forward_ip", want.forward_ip, forward_ip);
				if (hit !== want.hit)
					report_mismatch("hit", want.hit, hit);
				if (hit_index !== want.hit_index)
					report_mismatch("hit_index", want.hit_index, hit_index);
				if (learned !== want.learned)
					report_mismatch("learned", want.learned, learned);
				if (table_full !== want.table_full)
					report_mismatch("table_full", want.table_full, table_full);
				results_checked++;
				hits_seen += want.hit;
				learns_seen += want.learned;
				refusals_seen += want.table_full;
				drops_seen += !want.forward;
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", idle_cycles);
				$display("learning_mac_ip_route_table_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [lmr_pkg::FUNC_W-1:0] f;
		logic [lmr_pkg::MAC_W-1:0] m;
		logic [lmr_pkg::IP_W-1:0] phase_ip [PHASES];
		int sel;

		arst_n = 1'b0;
		in_valid = 1'b0;
		func = '0;
		dest_mac = '0;
		src_ip = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		items_sent = 0;
		burst_left = 0;
		known_count = 0;
		route_server_ip = lmr_pkg::SERVER_IP_RST;

		directed_rows[0] = mk_row(lmr_pkg::FUNC_DOWN, '0, '0, 1, DROPPED);
		directed_rows[1] = mk_row(FUNC_OTHER, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1, DROPPED);
		directed_rows[2] = mk_row(FUNC_RSVD, '1, '1, 1, DROPPED);
		directed_rows[3] = mk_row(lmr_pkg::FUNC_UP, '0, '1, 1,
			'{1, 1, lmr_pkg::SERVER_IP_RST, 0, 0, 1, 0});
		directed_rows[4] = mk_row(lmr_pkg::FUNC_DOWN, '0, '0, 1,
			'{1, 0, 32'hFFFF_FFFF, 1, 0, 0, 0});
		directed_rows[5] = mk_row(lmr_pkg::FUNC_UP, '1, '0, 1,
			'{1, 1, lmr_pkg::SERVER_IP_RST, 0, 0, 1, 0});
		directed_rows[6] = mk_row(lmr_pkg::FUNC_DOWN, '1, 32'h1234_5678, 1,
			'{1, 0, 0, 1, 1, 0, 0});
		directed_rows[7] = mk_row(lmr_pkg::FUNC_UP, '0, 32'h0000_1234, 1,
			'{1, 1, lmr_pkg::SERVER_IP_RST, 1, 0, 0, 0});
		for (int i = 0; i < 14; i++)
			directed_rows[8 + i] = mk_row(lmr_pkg::FUNC_UP, 48'h0200_0000_0000 | i, $urandom,
				0, DROPPED);
		directed_rows[22] = mk_row(lmr_pkg::FUNC_UP, 48'h0200_0000_00FF, $urandom, 1,
			'{1, 1, lmr_pkg::SERVER_IP_RST, 0, 0, 0, 1});
		directed_rows[23] = mk_row(lmr_pkg::FUNC_DOWN, 48'h0200_0000_000D, '0, 0, DROPPED);
		directed_rows[24] = mk_row(lmr_pkg::FUNC_DOWN, 48'h0000_0000_0001, '0, 1, DROPPED);

		phase_ip[0] = '0;
		phase_ip[1] = '1;
		phase_ip[2] = $urandom;
		phase_ip[3] = $urandom;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_route(directed_rows[i].func, directed_rows[i].mac, directed_rows[i].ip,
				directed_rows[i].typed, directed_rows[i].res);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			write_server_ip(phase_ip[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 8)
					f = (sel < 4) ? FUNC_OTHER : FUNC_RSVD;
				else if (sel < 50)
					f = lmr_pkg::FUNC_DOWN;
				else
					f = lmr_pkg::FUNC_UP;
				sel = $urandom_range(0, 99);
				if (sel < 70) begin
					m = known_macs[$urandom_range(0, known_count - 1)];
					// near miss: one bit off a stored key
					if (sel >= 55)
						m[$urandom_range(0, lmr_pkg::MAC_W - 1)] ^= 1'b1;
				end else begin
					m = {16'($urandom), $urandom};
				end
				send_route(f, m, $urandom, 0, DROPPED);
			end
		end

		wait_idle();

		$display("%0d messages sent over %0d server address settings, %0d results checked",
			items_sent, PHASES + 1, results_checked);
		$display("%0d hits, %0d entries learned, %0d learns refused on a full table, %0d dropped",
			hits_seen, learns_seen, refusals_seen, drops_seen);
		if (errors == 0) begin
			$display("learning_mac_ip_route_table_tb: PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("learning_mac_ip_route_table_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/lmr_pkg.sv
hdl/lmr_cell.sv
hdl/learning_mac_ip_route_table.sv
verif/learning_mac_ip_route_table_tb.sv
